/* rtl/core/tepe_pkg.sv */
// ----------------------------------------------------------------------------
// tepe_pkg
// Shared types and constants of the typed edge path expander: payload
// structs, command and status codes, controller to datapath signal groups.
// ----------------------------------------------------------------------------
package tepe_pkg;

  localparam int VERTICES   = 32;
  localparam int EDGE_TYPES = 4;

  localparam int VW     = $clog2(VERTICES);
  localparam int TW     = $clog2(EDGE_TYPES);
  localparam int DEPTH  = EDGE_TYPES * VERTICES;
  localparam int AW     = $clog2(DEPTH);
  localparam int DATA_W = 32;
  localparam int APB_AW = 3;

  typedef logic [VERTICES-1:0]   vmask_t;
  typedef logic [EDGE_TYPES-1:0] tmask_t;
  typedef logic [AW-1:0]         addr_t;

  // input item commands
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_HOP   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_VERTEX = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE   = 2'd2;

  // configuration register indexes
  localparam logic REG_VMASK = 1'b0;
  localparam logic REG_TMASK = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] from_vertex;
    logic [4:0] to_vertex;
    logic [1:0] conn_type;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] reachable_mask;
    logic        done_res;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic add_rd;
    logic add_wr;
    logic hop_init;
    logic scan_step;
    logic hop_commit;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_add;
    logic is_hop;
    logic add_ok;
    logic hop_go;
    logic scan_last;
  } dp_sts_t;

endpackage

/* rtl/core/tepe_regs.sv */
// ----------------------------------------------------------------------------
// tepe_regs
// Configuration register file: vertex and edge type presence masks behind
// an APB-style port.
// ----------------------------------------------------------------------------
module tepe_regs import tepe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output vmask_t            vmask_o,
  output tmask_t            tmask_o
);

  vmask_t vmask_q, vmask_d;
  tmask_t tmask_q, tmask_d;
  logic   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    vmask_d = vmask_q;
    tmask_d = tmask_q;
    if (wr_en) begin
      case (paddr[2])
        REG_VMASK: vmask_d = pwdata[VERTICES-1:0];
        REG_TMASK: tmask_d = pwdata[EDGE_TYPES-1:0];
        default:   vmask_d = vmask_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmask_q <= '0;
      tmask_q <= '0;
    end else begin
      vmask_q <= vmask_d;
      tmask_q <= tmask_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VMASK: prdata = DATA_W'(vmask_q);
      REG_TMASK: prdata = DATA_W'(tmask_q);
      default:   prdata = '0;
    endcase
  end

  assign vmask_o = vmask_q;
  assign tmask_o = tmask_q;

endmodule

/* rtl/core/tepe_dp.sv */
// ----------------------------------------------------------------------------
// tepe_dp
// Datapath: item latch, adjacency store with per-entry valid bits, frontier
// and sticky error, hop accumulator and the result register.
// ----------------------------------------------------------------------------
module tepe_dp import tepe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  vmask_t    vmask_i,
  input  tmask_t    tmask_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output logic      res_valid_o,
  output out_item_t res_o
);

  in_item_t  item_q;
  vmask_t    frontier_q, frontier_d;
  logic [1:0] err_q, err_d;
  vmask_t    acc_q, acc_d;
  logic [VW-1:0] scan_q;
  logic      hit_q;
  vmask_t    rd_data_q;
  logic      rd_vld_q;
  vmask_t    mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  out_item_t res_q, res_d;
  logic      res_valid_q;

  logic      from_ok, to_ok, type_ok, add_ok;
  logic [1:0] add_status;
  addr_t     edge_addr, rd_addr;
  logic      rd_en;
  vmask_t    rd_word, new_word;

  assign from_ok = (int'(item_q.from_vertex) < VERTICES) && vmask_i[item_q.from_vertex];
  assign to_ok   = (int'(item_q.to_vertex) < VERTICES) && vmask_i[item_q.to_vertex];
  assign type_ok = (int'(item_q.conn_type) < EDGE_TYPES) && tmask_i[item_q.conn_type];
  assign add_ok  = from_ok & to_ok & type_ok;

  always_comb begin
    if (!from_ok || !to_ok) begin
      add_status = ST_BAD_VERTEX;
    end else if (!type_ok) begin
      add_status = ST_BAD_TYPE;
    end else begin
      add_status = ST_OK;
    end
  end

  assign sts_o.is_add    = (item_q.cmd == CMD_ADD);
  assign sts_o.is_hop    = (item_q.cmd == CMD_HOP);
  assign sts_o.add_ok    = add_ok;
  assign sts_o.hop_go    = (err_q == ST_OK) && type_ok;
  assign sts_o.scan_last = (scan_q == VW'(VERTICES - 1));

  assign edge_addr = {item_q.conn_type[TW-1:0], item_q.from_vertex[VW-1:0]};
  assign rd_addr   = cmd_i.scan_step ? {item_q.conn_type[TW-1:0], scan_q} : edge_addr;
  assign rd_en     = cmd_i.scan_step | cmd_i.add_rd;

  // entries never written read as zero
  assign rd_word  = rd_vld_q ? rd_data_q : '0;
  assign new_word = rd_word | (vmask_t'(1) << item_q.to_vertex);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (cmd_i.add_wr) begin
      mem_q[edge_addr] <= new_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.add_wr) begin
      valid_q[edge_addr] <= 1'b1;
    end
  end

  // accumulate the neighbor word read in the previous cycle
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.hop_init) begin
      acc_d = '0;
    end else if (hit_q) begin
      acc_d = acc_q | rd_word;
    end
  end

  always_comb begin
    frontier_d = frontier_q;
    err_d      = err_q;
    res_d      = res_q;
    if (cmd_i.hop_commit) begin
      frontier_d = acc_d;
    end
    if (cmd_i.finish) begin
      res_d = '0;
      case (item_q.cmd)
        CMD_ADD: begin
          res_d.status = add_status;
        end
        CMD_BEGIN, CMD_HOP: begin
          if (item_q.cmd == CMD_BEGIN) begin
            err_d      = from_ok ? ST_OK : ST_BAD_VERTEX;
            frontier_d = from_ok ? (vmask_t'(1) << item_q.from_vertex) : '0;
          end else if (err_q == ST_OK && !type_ok) begin
            err_d = ST_BAD_TYPE;
          end
          res_d.status   = err_d;
          res_d.done_res = item_q.last;
          if (item_q.last && err_d == ST_OK) begin
            res_d.reachable_mask = 32'(frontier_d);
          end
        end
        default: res_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frontier_q  <= '0;
      err_q       <= ST_OK;
      scan_q      <= '0;
      hit_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      frontier_q  <= frontier_d;
      err_q       <= err_d;
      res_valid_q <= cmd_i.finish;
      hit_q       <= cmd_i.scan_step & frontier_q[scan_q];
      if (rd_en) begin
        rd_vld_q <= valid_q[rd_addr];
      end
      if (cmd_i.hop_init) begin
        scan_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + VW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_res_follows_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q == $past(cmd_i.finish))
    else $error("result strobe not one cycle after finish");

  a_err_sticky_on_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && item_q.cmd == CMD_HOP && err_q != ST_OK) |=> err_q == $past(err_q))
    else $error("held expansion error changed on hop");
`endif

endmodule

/* rtl/core/tepe_ctrl.sv */
// ----------------------------------------------------------------------------
// tepe_ctrl
// Controller: sequences item decode, the read-modify-write of an edge add
// and the per-vertex adjacency scan of a hop.
// ----------------------------------------------------------------------------
module tepe_ctrl import tepe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DECODE  = 7'b0000010,
    S_ADD_RD  = 7'b0000100,
    S_ADD_WR  = 7'b0001000,
    S_HOP     = 7'b0010000,
    S_HOP_END = 7'b0100000,
    S_FIN     = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_add && sts_i.add_ok) begin
          state_d = S_ADD_RD;
        end else if (sts_i.is_hop && sts_i.hop_go) begin
          cmd_o.hop_init = 1'b1;
          state_d        = S_HOP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_FIN;
      end
      S_HOP: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_HOP_END;
        end
      end
      S_HOP_END: begin
        // last neighbor word lands in this cycle
        cmd_o.hop_commit = 1'b1;
        state_d          = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef ASSERT_OFF
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE) |=> state_q == S_DECODE)
    else $error("accepted transfer not decoded");

  a_scan_runs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOP && !sts_i.scan_last) |=> state_q == S_HOP)
    else $error("hop scan left early");

  a_fin_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |=> (state_q == S_IDLE && !busy_o))
    else $error("finish did not return to idle");
`endif

endmodule

/* rtl/core/typed_edge_path_expander.sv */
// ----------------------------------------------------------------------------
// typed_edge_path_expander
// Typed adjacency store of neighbor bitmasks with edge add, expansion begin
// and single-type hop commands; reports the reached vertex set.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer
//  command   start, busy, item_i                     start high and busy low
//  result    res_valid_o, res_o                      res_valid_o high, one cycle
//  config    psel, penable, pwrite, paddr, pwdata,   psel, penable, pwrite high
//            prdata, pready
//
//  begin, cmd 3 and rejected items: decode, then finish; result registered
//  edge add: decode, read, write, finish (read-modify-write of one word)
//  hop: decode, scan with one adjacency read per vertex, commit, finish;
//    reads come from the single-port store; busy drops with the result strobe
//  reset clears the store through per-entry valid bits at once
//  the receiver cannot stall; each result shows for one cycle only
// ----------------------------------------------------------------------------
module typed_edge_path_expander import tepe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  in_item_t          item_i,
  output logic              res_valid_o,
  output out_item_t         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  vmask_t  vmask;
  tmask_t  tmask;
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  tepe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .vmask_o (vmask),
    .tmask_o (tmask)
  );

  tepe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (dp_sts),
    .cmd_o   (dp_cmd)
  );

  tepe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .vmask_i     (vmask),
    .tmask_i     (tmask),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

/* verif/tb_typed_edge_path_expander.sv */
// ----------------------------------------------------------------------------
// tb_typed_edge_path_expander
// Self-checking bench for the typed edge path expander. Edge adds, expansion
// begins and hops go in through the start/busy port while the presence masks
// are changed over the APB port between phases. A scoreboard keeps its own
// copy of the adjacency store, frontier and error flag, predicts every result
// and checks the result strobes in order.
// ----------------------------------------------------------------------------
module tb_typed_edge_path_expander;
  import tepe_pkg::*;

  localparam logic [1:0] CMD_NOP      = 2'd3;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         MAX_REPORTS  = 10;
  localparam int         ITEM_W       = $bits(in_item_t);

  class reach_checker;
    vmask_t     adj [DEPTH];
    vmask_t     frontier;
    logic [1:0] hop_err;
    vmask_t     vmask;
    tmask_t     tmask;
    out_item_t  outcome_q [$];
    int         mismatches;

    function new();
      foreach (adj[i]) adj[i] = '0;
      frontier   = '0;
      hop_err    = ST_OK;
      vmask      = '0;
      tmask      = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [DATA_W-1:0] val);
      if (idx == REG_VMASK) vmask = val[VERTICES-1:0];
      else tmask = val[EDGE_TYPES-1:0];
    endfunction

    function out_item_t predict_outcome(in_item_t it);
      out_item_t r;
      vmask_t    nxt;
      r = '0;
      case (it.cmd)
        CMD_ADD: begin
          if (!vmask[it.from_vertex] || !vmask[it.to_vertex]) begin
            r.status = ST_BAD_VERTEX;
          end else if (!tmask[it.conn_type]) begin
            r.status = ST_BAD_TYPE;
          end else begin
            adj[it.conn_type * VERTICES + it.from_vertex][it.to_vertex] = 1'b1;
          end
        end
        CMD_BEGIN, CMD_HOP: begin
          if (it.cmd == CMD_BEGIN) begin
            if (vmask[it.from_vertex]) begin
              hop_err  = ST_OK;
              frontier = vmask_t'(1) << it.from_vertex;
            end else begin
              hop_err  = ST_BAD_VERTEX;
              frontier = '0;
            end
          end else if (hop_err == ST_OK) begin
            // an error holds the frontier until the next begin
            if (!tmask[it.conn_type]) begin
              hop_err = ST_BAD_TYPE;
            end else begin
              nxt = '0;
              for (int v = 0; v < VERTICES; v++)
                if (frontier[v]) nxt |= adj[it.conn_type * VERTICES + v];
              frontier = nxt;
            end
          end
          r.status = hop_err;
          if (it.last) begin
            r.done_res = 1'b1;
            if (hop_err == ST_OK) r.reachable_mask = frontier;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_command(in_item_t it);
      outcome_q.insert(outcome_q.size(), predict_outcome(it));
    endfunction

    function void report_fault(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void check_outcome(out_item_t got);
      out_item_t want;
      if (outcome_q.size() == 0) begin
        report_fault($sformatf("result with nothing pending: status %0d mask %h done %0d",
                               got.status, got.reachable_mask, got.done_res));
        return;
      end
      want = outcome_q.pop_front();
      if (got.status !== want.status || got.reachable_mask !== want.reachable_mask ||
          got.done_res !== want.done_res)
        report_fault($sformatf(
          "got status %0d mask %h done %0d, wanted status %0d mask %h done %0d",
          got.status, got.reachable_mask, got.done_res,
          want.status, want.reachable_mask, want.done_res));
    endfunction
  endclass

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              start    = 1'b0;
  logic              busy;
  in_item_t          cmd_item = '0;
  logic              res_valid;
  out_item_t         res;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [APB_AW-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  reach_checker sb = new();
  vmask_t       cur_vmask = '0;
  tmask_t       cur_tmask = '0;
  bit           idle_on   = 1'b1;
  int           cycle_count = 0;

  typed_edge_path_expander i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (cmd_item),
    .res_valid_o(res_valid),
    .res_o      (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result checked before the command of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid) sb.check_outcome(res);
      if (start && !busy) sb.note_command(cmd_item);
      if (psel && penable && pwrite && pready) sb.set_reg(paddr[2], pwdata);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] cmd, int fv, int tv, int ty, bit last);
    in_item_t it;
    it.cmd         = cmd;
    it.from_vertex = fv[4:0];
    it.to_vertex   = tv[4:0];
    it.conn_type   = ty[1:0];
    it.last        = last;
    return it;
  endfunction

  // mostly a present vertex, now and then any index
  function automatic logic [4:0] pick_vertex();
    logic [4:0] v;
    v = 5'($urandom_range(0, 31));
    if (cur_vmask != '0 && $urandom_range(0, 9) != 0)
      while (!cur_vmask[v]) v = v + 1'b1;
    return v;
  endfunction

  function automatic logic [1:0] pick_type();
    logic [1:0] t;
    t = 2'($urandom_range(0, 3));
    if (cur_tmask != '0 && $urandom_range(0, 9) != 0)
      while (!cur_tmask[t]) t = t + 1'b1;
    return t;
  endfunction

  // returns at the edge of the transfer with start still high
  task automatic send_item(in_item_t it);
    start    <= 1'b1;
    cmd_item <= it;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (busy);
      end
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic issue(in_item_t it);
    send_item(it);
    pause();
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.outcome_q.size() != 0 || busy) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(vmask_t vm, tmask_t tm);
    drain();
    write_reg(REG_VMASK, DATA_W'(vm));
    write_reg(REG_TMASK, DATA_W'(tm));
    cur_vmask = vm;
    cur_tmask = tm;
  endtask

  task automatic run_random(int n_items);
    int       sent;
    int       hops;
    int       roll;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        repeat ($urandom_range(1, 8)) begin
          issue(make_item(CMD_ADD, int'(pick_vertex()), int'(pick_vertex()),
                          int'(pick_type()), 1'($urandom_range(0, 1))));
          sent++;
        end
      end else if (roll < 85) begin
        // begin followed by up to five hops, last set on the final one and now and then earlier
        hops = $urandom_range(0, 5);
        issue(make_item(CMD_BEGIN, int'(pick_vertex()), $urandom_range(0, 31),
                        $urandom_range(0, 3), hops == 0));
        sent++;
        for (int h = 1; h <= hops; h++) begin
          issue(make_item(CMD_HOP, $urandom_range(0, 31), $urandom_range(0, 31),
                          int'(pick_type()), h == hops || $urandom_range(0, 9) == 0));
          sent++;
        end
      end else begin
        it = in_item_t'(ITEM_W'($urandom));
        issue(it);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing present yet
    issue(make_item(CMD_ADD, 0, 31, 0, 1'b1));
    issue(make_item(CMD_HOP, 0, 0, 0, 1'b1));
    issue(make_item(CMD_BEGIN, 31, 0, 3, 1'b1));
    issue(make_item(CMD_NOP, 31, 31, 3, 1'b1));

    configure('1, '1);
    issue(make_item(CMD_ADD, 0, 31, 0, 1'b0));
    issue(make_item(CMD_ADD, 31, 0, 3, 1'b0));
    issue(make_item(CMD_ADD, 31, 31, 3, 1'b0));
    issue(make_item(CMD_ADD, 0, 0, 0, 1'b1));
    issue(make_item(CMD_ADD, 0, 5, 0, 1'b0));
    issue(make_item(CMD_ADD, 5, 17, 1, 1'b0));
    issue(make_item(CMD_BEGIN, 0, 0, 0, 1'b0));
    issue(make_item(CMD_HOP, 0, 0, 0, 1'b1));
    issue(make_item(CMD_BEGIN, 31, 0, 0, 1'b0));
    issue(make_item(CMD_HOP, 0, 0, 3, 1'b0));
    issue(make_item(CMD_HOP, 0, 0, 3, 1'b1));
    issue(make_item(CMD_NOP, 0, 0, 0, 1'b1));

    // only vertices 0 and 31, types 0 and 2
    configure(vmask_t'(32'h8000_0001), tmask_t'(4'b0101));
    issue(make_item(CMD_ADD, 0, 5, 0, 1'b0));
    issue(make_item(CMD_ADD, 0, 31, 1, 1'b0));
    issue(make_item(CMD_ADD, 5, 31, 3, 1'b1));
    issue(make_item(CMD_BEGIN, 5, 0, 0, 1'b0));
    issue(make_item(CMD_HOP, 0, 0, 0, 1'b1));
    issue(make_item(CMD_BEGIN, 0, 0, 0, 1'b0));
    issue(make_item(CMD_HOP, 0, 0, 1, 1'b0));
    issue(make_item(CMD_HOP, 0, 0, 0, 1'b1));
    // edges to vertex 5 still count although it is absent now
    issue(make_item(CMD_BEGIN, 0, 0, 0, 1'b0));
    issue(make_item(CMD_HOP, 0, 0, 0, 1'b1));

    configure('1, '1);
    run_random(200);
    configure(vmask_t'($urandom), tmask_t'($urandom_range(0, 15)));
    run_random(130);
    configure(vmask_t'(32'h0000_FFFF), tmask_t'(4'b0011));
    run_random(120);
    configure(vmask_t'($urandom), tmask_t'($urandom_range(0, 15)));
    run_random(130);
    configure('0, '0);
    run_random(40);
    configure('1, '1);
    idle_on = 1'b0;
    run_random(200);

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.outcome_q.size() != 0)
      $display("%0d results never arrived", sb.outcome_q.size());
    if (sb.mismatches == 0 && sb.outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
